>>> src/assert_macros.svh
// assertion helpers used by mtt_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/mtt_pkg.sv
package mtt_pkg;

   localparam int NUM_TIMERS  = 8;
   localparam int NUM_EVENTS  = 8;
   localparam int NUM_SLOTS   = (NUM_TIMERS > NUM_EVENTS) ? NUM_TIMERS : NUM_EVENTS;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS);
   localparam int TIME_W      = 32;
   localparam int SLOT_W      = 3;

   localparam logic [TIME_W-1:0] DISARMED = '1;

   typedef enum logic [2:0] {
      FUNC_TICK     = 3'd0,
      FUNC_ARM      = 3'd1,
      FUNC_ENABLE   = 3'd2,
      FUNC_SIGNAL   = 3'd3,
      FUNC_CLEAR    = 3'd4,
      FUNC_DISPATCH = 3'd5,
      FUNC_READ     = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_EVENT = 2'd1,
      KIND_TIMER = 2'd2,
      KIND_TIME  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CELL_IDLE,
      CELL_ARM,
      CELL_ENABLE,
      CELL_SIGNAL,
      CELL_CLEAR,
      CELL_LOAD,
      CELL_POP_EV,
      CELL_POP_TM
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_DISP
   } state_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      cell_op_type       op;
      logic [TIME_W-1:0] value;
      logic              enable;
      logic              due;
      logic [TIME_W-1:0] now;
   } cell_cmd_type;

   // handed from each cell to its lower neighbour
   typedef struct packed {
      logic ev;
      logic ev2;
      logic tm;
      logic tm2;
      logic due;
   } chain_type;

endpackage

>>> src/mtt_cell.sv
module mtt_cell
   import mtt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  logic         sel,
   input  logic         has_timer,
   input  logic         has_event,
   input  chain_type    chain_in,
   output chain_type    chain_out,
   output logic         pick_ev,
   output logic         pick_tm
);

   logic [TIME_W-1:0] deadline_ff, deadline_in;
   logic              enabled_ff, enabled_in;
   logic              signalled_ff, signalled_in;
   logic              pend_ev_ff, pend_ev_in;
   logic              pend_tm_ff, pend_tm_in;
   logic              expired;

   assign expired = has_timer & (deadline_ff < cmd.now);

   assign pick_ev = pend_ev_ff & ~chain_in.ev;
   assign pick_tm = pend_tm_ff & ~chain_in.tm;

   assign chain_out.ev  = chain_in.ev | pend_ev_ff;
   assign chain_out.ev2 = chain_in.ev2 | (chain_in.ev & pend_ev_ff);
   assign chain_out.tm  = chain_in.tm | pend_tm_ff;
   assign chain_out.tm2 = chain_in.tm2 | (chain_in.tm & pend_tm_ff);
   assign chain_out.due = chain_in.due | expired;

   always_comb begin
      deadline_in  = deadline_ff;
      enabled_in   = enabled_ff;
      signalled_in = signalled_ff;
      pend_ev_in   = pend_ev_ff;
      pend_tm_in   = pend_tm_ff;
      unique case (cmd.op)
         CELL_IDLE: begin
         end
         CELL_ARM: begin
            if (sel && has_timer) deadline_in = cmd.value;
         end
         CELL_ENABLE: begin
            if (sel && has_event) enabled_in = cmd.enable;
         end
         CELL_SIGNAL: begin
            if (sel && has_event && enabled_ff) signalled_in = 1'b1;
         end
         CELL_CLEAR: begin
            if (sel && has_event) signalled_in = 1'b0;
         end
         CELL_LOAD: begin
            // snapshot what this dispatch reports, disarm expired timers now if a tick set due
            pend_ev_in = signalled_ff & has_event;
            pend_tm_in = cmd.due & expired;
            if (cmd.due && expired) deadline_in = DISARMED;
         end
         CELL_POP_EV: begin
            if (pick_ev) pend_ev_in = 1'b0;
         end
         CELL_POP_TM: begin
            if (pick_tm) pend_tm_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_ff  <= DISARMED;
         enabled_ff   <= 1'b0;
         signalled_ff <= 1'b0;
         pend_ev_ff   <= 1'b0;
         pend_tm_ff   <= 1'b0;
      end else begin
         deadline_ff  <= deadline_in;
         enabled_ff   <= enabled_in;
         signalled_ff <= signalled_in;
         pend_ev_ff   <= pend_ev_in;
         pend_tm_ff   <= pend_tm_in;
      end
   end

endmodule

>>> src/ms_tick_timer_and_event_dispatcher_core.sv
// millisecond tick timer with one-shot timers and event dispatch
//
// request channel (req_*): one beat per command, func selects tick, arm, event
// enable, signal, clear, dispatch or read time. req_stall is high while a
// command is being worked on and while the result register is full and stalled.
// result channel (rsp_*): registered, rsp_last marks the final beat of a command.
// tick counts, then compares across every timer cell in the tick state;
// arm, enable, signal and clear are applied as they are taken and give no result.
// read time gives one beat in the cycle after the command is taken.
// dispatch loads its reports into the cells and holds the request side until
// its last beat is registered, giving one beat per cycle: signalled events from
// the highest index down, then expired timers if a tick has flagged one as due,
// at most sixteen beats; a dispatch with nothing to report gives one beat of
// kind none. the row of cells picks the next report by a priority chain.
// a stall on the result side holds the current beat and pauses the dispatch.
// reset clears the count, disarms every timer and clears all event bits.
module ms_tick_timer_and_event_dispatcher_core
   import mtt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_func,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [TIME_W-1:0] req_delay,
   input  logic              req_enable,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_kind,
   output logic [SLOT_W-1:0] rsp_index,
   output logic [TIME_W-1:0] rsp_time_res,
   output logic              rsp_last
);

   state_type         state_ff, state_in;
   logic [TIME_W-1:0] count_ff, count_in;
   logic              due_ff, due_in;
   logic [CNT_W-1:0]  res_cnt_ff, res_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0] rsp_index_ff, rsp_index_in;
   logic [TIME_W-1:0] rsp_time_ff, rsp_time_in;
   logic              rsp_last_ff, rsp_last_in;

   cell_cmd_type      cmd;
   chain_type         chain_link [NUM_SLOTS:0];
   logic [NUM_SLOTS-1:0] slot_sel, pick_ev, pick_tm;
   logic [SLOT_W-1:0] ev_idx, tm_idx;
   logic              out_free, accept, at_limit;
   func_type          func;

   assign chain_link[NUM_SLOTS] = '0;

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      assign slot_sel[i] = (int'(req_slot) == i);
      mtt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .sel       (slot_sel[i]),
         .has_timer (i < NUM_TIMERS),
         .has_event (i < NUM_EVENTS),
         .chain_in  (chain_link[i+1]),
         .chain_out (chain_link[i]),
         .pick_ev   (pick_ev[i]),
         .pick_tm   (pick_tm[i])
      );
   end

   // one-hot pick to index
   always_comb begin
      ev_idx = '0;
      tm_idx = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (pick_ev[i]) ev_idx = ev_idx | SLOT_W'(i);
         if (pick_tm[i]) tm_idx = tm_idx | SLOT_W'(i);
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign func      = func_type'(req_func);
   assign at_limit  = (res_cnt_ff == CNT_W'(MAX_RESULTS - 1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      due_in       = due_ff;
      res_cnt_in   = res_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_index_in = rsp_index_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_last_in  = rsp_last_ff;
      cmd.op       = CELL_IDLE;
      cmd.value    = count_ff + req_delay;
      cmd.enable   = req_enable;
      cmd.due      = due_ff;
      cmd.now      = count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (func)
                  FUNC_TICK: begin
                     count_in = count_ff + 1'b1;
                     state_in = ST_TICK;
                  end
                  FUNC_ARM:    cmd.op = CELL_ARM;
                  FUNC_ENABLE: cmd.op = CELL_ENABLE;
                  FUNC_SIGNAL: cmd.op = CELL_SIGNAL;
                  FUNC_CLEAR:  cmd.op = CELL_CLEAR;
                  FUNC_DISPATCH: begin
                     cmd.op     = CELL_LOAD;
                     due_in     = 1'b0;
                     res_cnt_in = '0;
                     state_in   = ST_DISP;
                  end
                  FUNC_READ: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_TIME;
                     rsp_index_in = '0;
                     rsp_time_in  = count_ff;
                     rsp_last_in  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TICK: begin
            // count_ff already holds the new time here
            if (chain_link[0].due) due_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DISP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_time_in  = '0;
               res_cnt_in   = res_cnt_ff + 1'b1;
               priority if (chain_link[0].ev) begin
                  cmd.op       = CELL_POP_EV;
                  rsp_kind_in  = KIND_EVENT;
                  rsp_index_in = ev_idx;
                  rsp_last_in  = !(chain_link[0].ev2 || chain_link[0].tm) || at_limit;
               end else if (chain_link[0].tm) begin
                  cmd.op       = CELL_POP_TM;
                  rsp_kind_in  = KIND_TIMER;
                  rsp_index_in = tm_idx;
                  rsp_last_in  = !chain_link[0].tm2 || at_limit;
               end else begin
                  rsp_kind_in  = KIND_NONE;
                  rsp_index_in = '0;
                  rsp_last_in  = 1'b1;
               end
               if (rsp_last_in) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         due_ff       <= 1'b0;
         res_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         due_ff       <= due_in;
         res_cnt_ff   <= res_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_index_ff <= rsp_index_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_index    = rsp_index_ff;
   assign rsp_time_res = rsp_time_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

>>> src/mtt_checker.sv
`include "assert_macros.svh"

module mtt_checker
   import mtt_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [2:0]        req_func,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [1:0]        rsp_kind,
   input logic [SLOT_W-1:0] rsp_index,
   input logic [TIME_W-1:0] rsp_time_res,
   input logic              rsp_last
);

   logic tick_beat;
   logic rsp_not_time;

   assign tick_beat    = req_valid && !req_stall && (req_func == FUNC_TICK);
   assign rsp_not_time = rsp_valid && (rsp_kind != KIND_TIME);

   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_IMPLY(a_time_only_read, clock, reset, rsp_not_time, rsp_time_res == '0)
   `ASSERT_IMPLY(a_read_single, clock, reset, rsp_valid && rsp_kind == KIND_TIME, rsp_last && rsp_index == '0)
   `ASSERT_IMPLY(a_none_single, clock, reset, rsp_valid && rsp_kind == KIND_NONE, rsp_last && rsp_index == '0)
   `ASSERT_NEXT(a_tick_busy, clock, reset, tick_beat, req_stall)

endmodule

bind ms_tick_timer_and_event_dispatcher_core mtt_checker u_mtt_checker (.*);

>>> test/ms_tick_timer_and_event_dispatcher_checker.sv
module ms_tick_timer_and_event_dispatcher_checker
   import mtt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [2:0]        req_func,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [TIME_W-1:0] req_delay,
   input  logic              req_enable,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [1:0]        rsp_kind,
   input  logic [SLOT_W-1:0] rsp_index,
   input  logic [TIME_W-1:0] rsp_time_res,
   input  logic              rsp_last,
   output int unsigned       fail_count,
   output int unsigned       reports_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      kind_type          kind;
      logic [SLOT_W-1:0] index;
      logic [TIME_W-1:0] time_res;
      logic              last;
   } report_type;

   logic [TIME_W-1:0]     ms_now;
   logic [TIME_W-1:0]     timer_deadline [NUM_TIMERS];
   logic                  timers_due;
   logic [NUM_EVENTS-1:0] event_on;
   logic [NUM_EVENTS-1:0] event_raised;
   report_type            owed_reports [$];
   int                    batch_n;

   function automatic void queue_report(kind_type kind, int idx, logic [TIME_W-1:0] t);
      report_type r;
      // reports past the sixteenth are dropped, state updates still happen
      if (batch_n < MAX_RESULTS) begin
         r.kind     = kind;
         r.index    = SLOT_W'(idx);
         r.time_res = t;
         r.last     = 1'b0;
         owed_reports.push_back(r);
         batch_n++;
      end
   endfunction

   function automatic void apply_command(logic [2:0] func, logic [SLOT_W-1:0] slot,
                                         logic [TIME_W-1:0] delay, logic en);
      report_type tail;
      batch_n = 0;
      case (func)
         FUNC_TICK: begin
            ms_now = ms_now + 1'b1;
            for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
               if (timer_deadline[i] < ms_now) timers_due = 1'b1;
            end
         end
         FUNC_ARM: begin
            if (slot < NUM_TIMERS) timer_deadline[slot] = ms_now + delay;
         end
         FUNC_ENABLE: begin
            if (slot < NUM_EVENTS) event_on[slot] = en;
         end
         FUNC_SIGNAL: begin
            if (slot < NUM_EVENTS && event_on[slot]) event_raised[slot] = 1'b1;
         end
         FUNC_CLEAR: begin
            if (slot < NUM_EVENTS) event_raised[slot] = 1'b0;
         end
         FUNC_DISPATCH: begin
            for (int i = NUM_EVENTS - 1; i >= 0; i--) begin
               if (event_raised[i]) queue_report(KIND_EVENT, i, '0);
            end
            // timers are only scanned when a tick has flagged one as due
            if (timers_due) begin
               for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
                  if (timer_deadline[i] < ms_now) begin
                     timer_deadline[i] = DISARMED;
                     queue_report(KIND_TIMER, i, '0);
                  end
               end
               timers_due = 1'b0;
            end
            if (batch_n == 0) queue_report(KIND_NONE, 0, '0);
         end
         FUNC_READ: begin
            queue_report(KIND_TIME, 0, ms_now);
         end
         default: begin
         end
      endcase
      if (batch_n > 0) begin
         tail = owed_reports.pop_back();
         tail.last = 1'b1;
         owed_reports.push_back(tail);
      end
   endfunction

   task automatic check_report();
      report_type want;
      if (owed_reports.size() == 0) begin
         $display("%0t: unexpected result beat kind %0d index %0d time %0h last %0b",
                  $time, rsp_kind, rsp_index, rsp_time_res, rsp_last);
         fail_count++;
      end else begin
         want = owed_reports.pop_front();
         if (rsp_kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, rsp_kind);
            fail_count++;
         end
         if (rsp_index !== want.index) begin
            $display("%0t: index expected %0d actual %0d", $time, want.index, rsp_index);
            fail_count++;
         end
         if (rsp_time_res !== want.time_res) begin
            $display("%0t: time expected %0h actual %0h", $time, want.time_res,
                     rsp_time_res);
            fail_count++;
         end
         if (rsp_last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_last);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ms_now       = '0;
         timers_due   = 1'b0;
         event_on     = '0;
         event_raised = '0;
         for (int i = 0; i < NUM_TIMERS; i++) timer_deadline[i] = DISARMED;
         owed_reports.delete();
         fail_count   = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_report();
         if (req_valid && !req_stall) apply_command(req_func, req_slot, req_delay, req_enable);
      end
      reports_owed = owed_reports.size();
   end

endmodule

>>> test/ms_tick_timer_and_event_dispatcher_core_tb.sv
module ms_tick_timer_and_event_dispatcher_core_tb;
   import mtt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] FUNC_SPARE = 3'd7;
   localparam int TOTAL_CMDS  = 430;
   localparam int HOLD_CYCLES = 300;
   // worst case is a full dispatch behind the long hold-off plus heavy stalling
   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 40;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [2:0]        req_func;
   logic [SLOT_W-1:0] req_slot;
   logic [TIME_W-1:0] req_delay;
   logic              req_enable;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_kind;
   logic [SLOT_W-1:0] rsp_index;
   logic [TIME_W-1:0] rsp_time_res;
   logic              rsp_last;

   int unsigned    fail_count;
   int unsigned    reports_owed;
   int             cmds_sent = 0;
   int             burst_left = 0;
   int             idle_cycles = 0;
   bit             hold_request = 1'b0;
   bit             hold_served = 1'b0;
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   ms_tick_timer_and_event_dispatcher_core u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_slot     (req_slot),
      .req_delay    (req_delay),
      .req_enable   (req_enable),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_index    (rsp_index),
      .rsp_time_res (rsp_time_res),
      .rsp_last     (rsp_last)
   );

   ms_tick_timer_and_event_dispatcher_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_slot     (req_slot),
      .req_delay    (req_delay),
      .req_enable   (req_enable),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_index    (rsp_index),
      .rsp_time_res (rsp_time_res),
      .rsp_last     (rsp_last),
      .fail_count   (fail_count),
      .reports_owed (reports_owed)
   );

   // result side back-pressure
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(10, 150);
         end
         mode_left--;
         case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 9) < 7);
            STALL_TOGGLE: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [TIME_W-1:0] pick_delay();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return TIME_W'($urandom_range(0, 6));
         5, 6:          return TIME_W'($urandom_range(7, 40));
         7:             return DISARMED - TIME_W'($urandom_range(0, 200)); // wraps past zero
         default:       return $urandom();
      endcase
   endfunction

   task automatic send_cmd(logic [2:0] func, logic [SLOT_W-1:0] slot,
                           logic [TIME_W-1:0] delay, logic en);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_func   <= func;
      req_slot   <= slot;
      req_delay  <= delay;
      req_enable <= en;
      do @(posedge clock); while (req_stall);
      if (func != FUNC_SPARE) cmds_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   // unused fields carry random values
   task automatic send_bare(logic [2:0] func);
      send_cmd(func, SLOT_W'($urandom_range(0, 7)), $urandom(), 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (reports_owed == 0);
   endtask

   // set up events and timers, let time pass, maybe read, then dispatch and maybe clear
   task automatic run_schedule(bit full);
      int n_events;
      int n_timers;
      int n_ticks;
      logic [SLOT_W-1:0] s;
      n_events = full ? NUM_EVENTS : $urandom_range(0, 3);
      n_timers = full ? NUM_TIMERS : $urandom_range(0, 3);
      n_ticks  = full ? 5 : $urandom_range(0, 6);
      for (int k = 0; k < n_events; k++) begin
         s = full ? SLOT_W'(k) : SLOT_W'($urandom_range(0, 7));
         send_cmd(FUNC_ENABLE, s, $urandom(), full ? 1'b1 : 1'($urandom_range(0, 3) != 0));
         send_cmd(FUNC_SIGNAL, s, $urandom(), 1'($urandom_range(0, 1)));
      end
      for (int k = 0; k < n_timers; k++) begin
         s = full ? SLOT_W'(k) : SLOT_W'($urandom_range(0, 7));
         send_cmd(FUNC_ARM, s, full ? TIME_W'($urandom_range(0, 3)) : pick_delay(),
                  1'($urandom_range(0, 1)));
      end
      for (int k = 0; k < n_ticks; k++) send_bare(FUNC_TICK);
      if ($urandom_range(0, 2) == 0) send_bare(FUNC_READ);
      send_bare(FUNC_DISPATCH);
      if ($urandom_range(0, 3) == 0) send_bare(FUNC_DISPATCH);
      repeat ($urandom_range(0, 2)) send_bare(FUNC_CLEAR);
   endtask

   // out-of-order steps: signal before enable, dispatch before any tick
   task automatic run_broken();
      logic [SLOT_W-1:0] s;
      s = SLOT_W'($urandom_range(0, 7));
      send_cmd(FUNC_SIGNAL, s, $urandom(), 1'($urandom_range(0, 1)));
      send_cmd(FUNC_ARM, s, '0, 1'($urandom_range(0, 1)));
      send_bare(FUNC_DISPATCH);
      send_cmd(FUNC_ENABLE, s, $urandom(), 1'b0);
      send_cmd(FUNC_SIGNAL, s, $urandom(), 1'($urandom_range(0, 1)));
      send_bare(FUNC_DISPATCH);
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_func   = FUNC_TICK;
      req_slot   = '0;
      req_delay  = '0;
      req_enable = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening
      send_bare(FUNC_READ);
      send_bare(FUNC_DISPATCH);
      send_cmd(FUNC_SIGNAL, 3'd3, '0, 1'b1);          // disabled, ignored
      send_cmd(FUNC_ENABLE, 3'd3, '0, 1'b1);
      send_cmd(FUNC_ENABLE, 3'd0, '1, 1'b1);
      send_cmd(FUNC_SIGNAL, 3'd3, '0, 1'b0);
      send_cmd(FUNC_SIGNAL, 3'd0, '1, 1'b1);
      send_cmd(FUNC_ENABLE, 3'd3, '0, 1'b0);          // signal stays set
      send_cmd(FUNC_ARM, 3'd7, '0, 1'b0);
      send_cmd(FUNC_ARM, 3'd5, 32'd1, 1'b1);          // equal to count, not yet due
      send_bare(FUNC_TICK);
      send_bare(FUNC_DISPATCH);
      send_bare(FUNC_DISPATCH);                       // signals persist, no timer scan
      send_bare(FUNC_TICK);
      send_cmd(FUNC_ARM, 3'd2, DISARMED, 1'b0);       // deadline wraps below count
      send_cmd(FUNC_CLEAR, 3'd3, '1, 1'b1);
      send_cmd(FUNC_SPARE, 3'd6, '1, 1'b1);
      send_bare(FUNC_DISPATCH);
      send_cmd(FUNC_ARM, 3'd1, DISARMED, 1'b1);       // passed, but flag is clear
      send_bare(FUNC_DISPATCH);
      send_cmd(FUNC_CLEAR, 3'd0, '0, 1'b0);
      send_bare(FUNC_TICK);
      send_bare(FUNC_READ);
      send_bare(FUNC_DISPATCH);
      wait_drained();

      // random part, opening with a full sixteen-beat dispatch
      run_schedule(1'b1);
      while (cmds_sent < TOTAL_CMDS) begin
         if (!hold_request && cmds_sent >= 200) begin
            hold_request = 1'b1;
            repeat (24) send_bare(($urandom_range(0, 1) == 0) ? FUNC_DISPATCH : FUNC_READ);
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: run_schedule(1'b0);
            6:       run_schedule(1'b1);
            7:       repeat ($urandom_range(1, 6)) begin
                        send_cmd(3'($urandom_range(0, 7)), SLOT_W'($urandom_range(0, 7)),
                                 ($urandom_range(0, 1) == 0) ? pick_delay() : $urandom(),
                                 1'($urandom_range(0, 1)));
                     end
            8:       send_bare(FUNC_READ);
            default: run_broken();
         endcase
         if ($urandom_range(0, 14) == 0) wait_drained();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && reports_owed == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/mtt_pkg.sv
src/mtt_cell.sv
src/ms_tick_timer_and_event_dispatcher_core.sv
src/mtt_checker.sv
test/ms_tick_timer_and_event_dispatcher_checker.sv
test/ms_tick_timer_and_event_dispatcher_core_tb.sv
